FILE: rtl/vsp_pkg.sv
package vsp_pkg;

    localparam int unsigned MAX_DATES_DEF = 4096;

    localparam int DATE_W    = 12;
    localparam int SPOT_W    = 32;
    localparam int LOG_W     = 32;
    localparam int SUM_W     = 64;
    localparam int FLOW_W    = 64;
    localparam int FRAC_BITS = 24;
    localparam int CFG_IDX_W = 8;

    // ln(2) as unsigned Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [CFG_IDX_W-1:0] CFG_MATURITY  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_FRAC = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIONAL  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE    = 8'd3;

    localparam logic [DATE_W-1:0] MATURITY_RST  = 12'd4095;
    localparam logic [31:0]       YEAR_FRAC_RST = 32'd16777216;

    typedef struct packed {
        logic [DATE_W-1:0] date_index;
        logic [SPOT_W-1:0] spot;
    } in_item_t;

    typedef struct packed {
        logic signed [FLOW_W-1:0] flow_value;
        logic                     saturated;
    } out_item_t;

    typedef struct packed {
        logic [DATE_W-1:0] maturity_index;
        logic [31:0]       year_fraction;
        logic signed [31:0] notional;
        logic [31:0]       strike_variance;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_SKIP  = 2'd0,
        KIND_SEED  = 2'd1,
        KIND_ACCUM = 2'd2
    } kind_t;

    typedef struct packed {
        logic [SPOT_W-1:0] spot;
        kind_t             kind;
        logic              pays;
    } job_t;

endpackage

FILE: rtl/vsp_front.sv
module vsp_front #(
    parameter int unsigned MAX_DATES = vsp_pkg::MAX_DATES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vsp_pkg::in_item_t s_item,
    input  vsp_pkg::cfg_t     cfg,
    output logic              job_valid,
    output vsp_pkg::job_t     job,
    input  logic              job_pop
);
    import vsp_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    job_t              queue_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push;
    logic              in_range;
    job_t              job_in;

    // classify the sample against the maturity date
    always_comb begin
        in_range       = (32'(s_item.date_index) < MAX_DATES);
        job_in.spot    = s_item.spot;
        job_in.pays    = in_range && (s_item.date_index == cfg.maturity_index);
        if (!in_range) begin
            job_in.kind = KIND_SKIP;
        end else if (s_item.date_index == '0) begin
            job_in.kind = KIND_SEED;
        end else if (s_item.date_index <= cfg.maturity_index) begin
            job_in.kind = KIND_ACCUM;
        end else begin
            job_in.kind = KIND_SKIP;
        end
    end

    assign s_ready   = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign push      = s_valid && s_ready;
    assign job_valid = (count_reg != '0);
    assign job       = queue_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push    ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = job_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !job_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && job_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= job_in;
        end
    end

endmodule

FILE: rtl/vsp_back.sv
module vsp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  vsp_pkg::cfg_t      cfg,
    input  logic               job_valid,
    input  vsp_pkg::job_t      job,
    output logic               job_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output vsp_pkg::out_item_t m_item
);
    import vsp_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_LOG   = 12'b0000_0000_0010,
        S_LN    = 12'b0000_0000_0100,
        S_APPLY = 12'b0000_0000_1000,
        S_ADD   = 12'b0000_0001_0000,
        S_DSET  = 12'b0000_0010_0000,
        S_DIV   = 12'b0000_0100_0000,
        S_DIFF  = 12'b0000_1000_0000,
        S_MLO   = 12'b0001_0000_0000,
        S_MHI   = 12'b0010_0000_0000,
        S_FIN   = 12'b0100_0000_0000,
        S_EMIT  = 12'b1000_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic               pays_reg, pays_next;
    logic [4:0]         p_reg, p_next;
    logic [31:0]        m_reg, m_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic signed [LOG_W-1:0] cur_reg, cur_next;
    logic signed [LOG_W-1:0] prev_reg, prev_next;
    logic [SUM_W-1:0]   sq_reg, sq_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               clamp_reg, clamp_next;
    logic [31:0]        rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [SUM_W-1:0]   dmag_reg, dmag_next;
    logic               rneg_reg, rneg_next;
    logic [63:0]        plo_reg, plo_next;
    logic [63:0]        phi_reg, phi_next;
    out_item_t          res_reg, res_next;
    out_item_t          out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    // datapath terms
    logic [4:0]         lead;
    logic [31:0]        m_init;
    logic [63:0]        m_sq;
    logic [32:0]        m_sh;
    logic signed [5:0]  exp_s;
    logic signed [29:0] l2;
    logic [28:0]        l2_mag;
    logic [61:0]        ln_prod;
    logic [29:0]        ln_mag;
    logic signed [32:0] diff;
    logic [31:0]        diff_mag;
    logic [64:0]        sum_wide;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [SUM_W-1:0]   rv;
    logic [31:0]        nmag;
    logic [95:0]        prod_full;
    logic [63:0]        lim;
    logic               prod_clamp;
    logic [63:0]        prod;

    always_comb begin
        lead = '0;
        for (int i = 0; i < SPOT_W; i++) begin
            if (job.spot[i]) begin
                lead = 5'(i);
            end
        end
    end

    assign m_init   = job.spot << (5'd31 - lead);
    assign m_sq     = m_reg * m_reg;
    assign m_sh     = m_sq[63:31];
    assign exp_s    = $signed({1'b0, p_reg}) - 6'sd16;
    assign l2       = $signed({exp_s, 24'b0}) + $signed({6'b0, frac_reg});
    assign l2_mag   = l2[29] ? 29'(-l2) : 29'(l2);
    assign ln_prod  = 62'(l2_mag) * 62'(LN2_Q32) + 62'h8000_0000;
    assign ln_mag   = ln_prod[61:32];
    assign diff     = 33'(cur_reg) - 33'(prev_reg);
    assign diff_mag = diff[32] ? 32'(-diff) : 32'(diff);
    assign sum_wide = {1'b0, sum_reg} + {1'b0, sq_reg};
    assign rem_sh   = {rem_reg, quo_reg[63]};
    assign rem_ge   = (rem_sh >= {1'b0, cfg.year_fraction});
    assign rv       = (cfg.year_fraction == '0) ? '0 : quo_reg;
    assign nmag     = cfg.notional[31] ? 32'(-cfg.notional) : 32'(cfg.notional);
    assign prod_full  = {phi_reg, 32'b0} + {32'b0, plo_reg};
    assign lim        = rneg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    assign prod_clamp = (prod_full > {32'b0, lim});
    assign prod       = prod_clamp ? lim : prod_full[63:0];

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        pays_next    = pays_reg;
        p_next       = p_reg;
        m_next       = m_reg;
        frac_next    = frac_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        sq_next      = sq_reg;
        sum_next     = sum_reg;
        clamp_next   = clamp_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dmag_next    = dmag_reg;
        rneg_next    = rneg_reg;
        plo_next     = plo_reg;
        phi_next     = phi_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        job_pop      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (job_valid) begin
                    job_pop   = 1'b1;
                    kind_next = job.kind;
                    pays_next = job.pays;
                    res_next  = '0;
                    case (job.kind)
                        KIND_SEED, KIND_ACCUM: begin
                            if (job.spot == '0) begin
                                cur_next   = {1'b1, 31'b0};
                                state_next = S_APPLY;
                            end else begin
                                p_next     = lead;
                                m_next     = m_init;
                                frac_next  = '0;
                                cnt_next   = '0;
                                state_next = S_LOG;
                            end
                        end
                        default: begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_LOG: begin
                // square, keep Q1.31, renormalize on overflow past 2.0
                m_next    = m_sh[32] ? m_sh[32:1] : m_sh[31:0];
                frac_next = {frac_reg[FRAC_BITS-2:0], m_sh[32]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 6'(FRAC_BITS - 1)) begin
                    state_next = S_LN;
                end
            end
            S_LN: begin
                cur_next   = l2[29] ? -$signed({2'b0, ln_mag}) : $signed({2'b0, ln_mag});
                state_next = S_APPLY;
            end
            S_APPLY: begin
                prev_next = cur_reg;
                if (kind_reg == KIND_SEED) begin
                    sum_next   = '0;
                    clamp_next = 1'b0;
                    state_next = pays_reg ? S_DSET : S_EMIT;
                end else begin
                    sq_next    = 64'(diff_mag) * 64'(diff_mag);
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                if (sum_wide[64]) begin
                    sum_next   = '1;
                    clamp_next = 1'b1;
                end else begin
                    sum_next = sum_wide[63:0];
                end
                state_next = pays_reg ? S_DSET : S_EMIT;
            end
            S_DSET: begin
                rem_next   = '0;
                quo_next   = sum_reg;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next = rem_ge ? 32'(rem_sh - {1'b0, cfg.year_fraction}) : rem_sh[31:0];
                quo_next = {quo_reg[62:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(SUM_W - 1)) begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                if (rv >= 64'(cfg.strike_variance)) begin
                    dmag_next = rv - 64'(cfg.strike_variance);
                    rneg_next = cfg.notional[31];
                end else begin
                    dmag_next = 64'(cfg.strike_variance) - rv;
                    rneg_next = !cfg.notional[31];
                end
                state_next = S_MLO;
            end
            S_MLO: begin
                plo_next   = 64'(dmag_reg[31:0]) * 64'(nmag);
                state_next = S_MHI;
            end
            S_MHI: begin
                phi_next   = 64'(dmag_reg[63:32]) * 64'(nmag);
                state_next = S_FIN;
            end
            S_FIN: begin
                res_next.flow_value = rneg_reg ? $signed(-prod) : $signed(prod);
                res_next.saturated  = prod_clamp || clamp_reg;
                state_next          = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            prev_reg    <= '0;
            sum_reg     <= '0;
            clamp_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            prev_reg    <= prev_next;
            sum_reg     <= sum_next;
            clamp_reg   <= clamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        pays_reg <= pays_next;
        p_reg    <= p_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        cnt_reg  <= cnt_next;
        cur_reg  <= cur_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dmag_reg <= dmag_next;
        rneg_reg <= rneg_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    a_log_normalized: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOG) |-> m_reg[31])
        else $error("log mantissa lost normalization");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && cfg.year_fraction != '0) |-> (rem_reg < cfg.year_fraction))
        else $error("divider remainder not below divisor");

    a_clamp_pins_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        clamp_reg |-> (sum_reg == '1))
        else $error("clamp flag set without saturated sum");

endmodule

FILE: rtl/variance_swap_payoff_unit.sv
// Realized variance swap payoff. Feed one spot sample (Q16.16) per date; date 0 seeds
// the path, later dates up to maturity_index add the squared log-return to a saturating
// Q16.48 sum, and the maturity date returns notional * (sum / year_fraction - strike)
// in Q40.24; every other date returns 0. Exactly one result per accepted item, in order.
// A nonzero spot gets its log from the 32x32 squaring unit (24 steps of the log); the
// maturity date adds the one-bit-a-cycle 64/32 divider. A zero spot skips the log, and
// a skipped date goes straight to the output register.
// A two-entry queue sits in front of the sequencer and the result has its own output
// register, so the input keeps taking items while a result waits until the queue fills.
// Write configuration only while the block is idle; cfg_ready is always high.
module variance_swap_payoff_unit #(
    parameter int unsigned MAX_DATES = vsp_pkg::MAX_DATES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  vsp_pkg::in_item_t               s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output vsp_pkg::out_item_t              m_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import vsp_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic job_valid;
    job_t job;
    logic job_pop;

    // register file: drop writes to unknown indexes
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MATURITY:  cfg_next.maturity_index  = cfg_data[DATE_W-1:0];
                CFG_YEAR_FRAC: cfg_next.year_fraction   = cfg_data;
                CFG_NOTIONAL:  cfg_next.notional        = $signed(cfg_data);
                CFG_STRIKE:    cfg_next.strike_variance = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.maturity_index  <= MATURITY_RST;
            cfg_reg.year_fraction   <= YEAR_FRAC_RST;
            cfg_reg.notional        <= '0;
            cfg_reg.strike_variance <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify each sample and hold it in the queue
    vsp_front #(
        .MAX_DATES (MAX_DATES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    // back: log, accumulate, divide, scale, and register the result
    vsp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

FILE: tb/sv/payoff_checker.sv
`timescale 1ns / 1ps

module payoff_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  vsp_pkg::in_item_t             s_item,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  vsp_pkg::out_item_t            m_item,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [vsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            failures,
    output int                            outstanding
);
    import vsp_pkg::*;

    localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic [DATE_W-1:0]  pay_date;
    logic [31:0]        annualizer;
    logic signed [31:0] cash_per_var;
    logic [31:0]        strike_q24;

    logic signed [31:0] last_log;
    longint unsigned    var_sum;
    bit                 var_sum_clamped;

    out_item_t expected_flows[$];

    // natural log of a Q16.16 spot as signed Q8.24
    function automatic logic signed [31:0] log_spot_q24(input logic [31:0] s);
        int              p;
        int              i;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned mag;
        longint          l2;
        bit              neg;
        if (s == 0) return 32'sh8000_0000;
        p = 31;
        while (!s[p]) p--;
        m = (64'(s) << (31 - p)) & 64'hFFFF_FFFF;
        frac = 0;
        for (i = 0; i < FRAC_BITS; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        l2 = longint'(p - 16) * (longint'(1) << FRAC_BITS) + longint'(frac);
        neg = l2 < 0;
        mag = neg ? longint'(-l2) : longint'(l2);
        mag = (mag * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
        return neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    endfunction

    // advance the path state with one sample and return the flow it pays
    function automatic out_item_t predict_flow(input in_item_t it);
        out_item_t       r;
        logic signed [31:0] cur;
        longint          d;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned rv;
        longint unsigned nmag;
        longint unsigned lim;
        longint unsigned prod;
        bit              dneg;
        bit              rneg;
        bit              clamp;
        r = '0;
        clamp = 0;
        if (it.date_index == 0) begin
            last_log = log_spot_q24(it.spot);
            var_sum = 0;
            var_sum_clamped = 0;
        end else if (it.date_index <= pay_date) begin
            cur = log_spot_q24(it.spot);
            d = longint'(cur) - longint'(last_log);
            mag = d < 0 ? longint'(-d) : longint'(d);
            sq = mag * mag;
            if (var_sum > SUM_MAX - sq) begin
                var_sum = SUM_MAX;
                var_sum_clamped = 1;
            end else begin
                var_sum = var_sum + sq;
            end
            last_log = cur;
        end
        if (it.date_index == pay_date) begin
            rv = (annualizer != 0) ? var_sum / 64'(annualizer) : 0;
            if (rv >= 64'(strike_q24)) begin
                mag = rv - 64'(strike_q24);
                dneg = 0;
            end else begin
                mag = 64'(strike_q24) - rv;
                dneg = 1;
            end
            nmag = cash_per_var < 0 ? longint'(-longint'(cash_per_var))
                                    : longint'(cash_per_var);
            rneg = dneg != (cash_per_var < 0);
            lim = rneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            if (mag != 0 && nmag > lim / mag) begin
                clamp = 1;
                prod = lim;
            end else begin
                prod = mag * nmag;
            end
            if (rneg) prod = 64'd0 - prod;
            r.flow_value = prod;
            r.saturated = clamp | var_sum_clamped;
        end
        return r;
    endfunction

    assign outstanding = expected_flows.size();

    always @(posedge aclk) begin
        out_item_t want;
        out_item_t fresh;
        if (!aresetn) begin
            pay_date <= MATURITY_RST;
            annualizer <= YEAR_FRAC_RST;
            cash_per_var <= '0;
            strike_q24 <= '0;
            failures <= 0;
            last_log = 0;
            var_sum = 0;
            var_sum_clamped = 0;
            expected_flows.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MATURITY:  pay_date <= cfg_data[DATE_W-1:0];
                    CFG_YEAR_FRAC: annualizer <= cfg_data;
                    CFG_NOTIONAL:  cash_per_var <= cfg_data;
                    CFG_STRIKE:    strike_q24 <= cfg_data;
                    default: ;
                endcase
            end
            // compare before queuing so a result never meets its own item
            if (m_valid && m_ready) begin
                if (expected_flows.size() == 0) begin
                    $error("unexpected result flow_value=%0d", m_item.flow_value);
                    failures <= failures + 1;
                end else begin
                    want = expected_flows.pop_front();
                    if (want.flow_value !== m_item.flow_value) begin
                        $error("flow_value expected %0d actual %0d",
                               want.flow_value, m_item.flow_value);
                        failures <= failures + 1;
                    end else if (want.saturated !== m_item.saturated) begin
                        $error("saturated expected %0b actual %0b",
                               want.saturated, m_item.saturated);
                        failures <= failures + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                fresh = predict_flow(s_item);
                expected_flows = {expected_flows, fresh};
            end
        end
    end

endmodule

FILE: tb/sv/tb_variance_swap_payoff_unit.sv
`timescale 1ns / 1ps

module tb_variance_swap_payoff_unit;
    import vsp_pkg::*;

    // run cap, generous against the per-item work plus receiver stalls
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ITEM_TARGET = 400;
    localparam logic [31:0] SPOT_ONE = 32'h0001_0000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_item;
    logic m_valid;
    logic m_ready;
    out_item_t m_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    int failures;
    int outstanding;
    int cycles = 0;
    int samples_sent;
    int burst_left;
    bit long_hold;

    variance_swap_payoff_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    payoff_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .outstanding(outstanding)
    );

    initial aclk = 0;
    always #5 aclk = ~aclk;

    // cap the run; a hang ends here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: switch among four stall styles, honor one long hold-off on request
    initial begin
        int mode;
        int n;
        bit hold_done;
        m_ready = 0;
        mode = 0;
        n = 0;
        hold_done = 0;
        forever begin
            @(posedge aclk);
            if (long_hold && !hold_done) begin
                // hold off long enough for the input queue to fill and stall
                m_ready <= 0;
                repeat (600) @(posedge aclk);
                hold_done = 1;
            end else begin
                if (n % 64 == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0:       m_ready <= 1;
                    1:       m_ready <= $urandom_range(0, 1);
                    2:       m_ready <= (n % 5) != 0;
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
            n++;
        end
    end

    // offer one sample; bursts of random length separated by random gaps
    task automatic send_sample(input logic [DATE_W-1:0] d, input logic [31:0] sp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1;
        s_item <= '{date_index: d, spot: sp};
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        samples_sent++;
    endtask

    // drop valid, let the checker queue the last item, drain every expected result
    task automatic drain;
        s_valid <= 0;
        burst_left = 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    // write all four registers back to back while idle
    task automatic load_terms(input logic [DATE_W-1:0] mat, input logic [31:0] yf,
                              input logic [31:0] notl, input logic [31:0] strike);
        logic [31:0] vals[4];
        logic [CFG_IDX_W-1:0] idx[4];
        int k;
        vals = '{32'(mat), yf, notl, strike};
        idx = '{CFG_MATURITY, CFG_YEAR_FRAC, CFG_NOTIONAL, CFG_STRIKE};
        for (k = 0; k < 4; k++) begin
            cfg_valid <= 1;
            cfg_index <= idx[k];
            cfg_data <= vals[k];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] pick_spot();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return $urandom_range(1, 255);
            default: return SPOT_ONE + $urandom_range(0, 32'h4000) - 32'h2000;
        endcase
    endfunction

    function automatic logic [31:0] pick_notional();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    initial begin
        int p;
        int t;
        int span;
        logic [DATE_W-1:0] mat;
        logic [31:0] yf;
        aresetn = 0;
        s_valid = 0;
        s_item = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        samples_sent = 0;
        burst_left = 0;
        long_hold = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset terms: notional 0, maturity 4095; walk a short path
        send_sample(0, SPOT_ONE);
        send_sample(1, 32'hFFFF_FFFF);
        drain();

        // directed path: zero spot, extreme spots, maturity, then past maturity
        load_terms(5, 32'h0100_0000, 32'd1000, 32'd0);
        send_sample(0, SPOT_ONE);
        send_sample(1, 32'h0);
        send_sample(2, 32'hFFFF_FFFF);
        send_sample(3, 32'h1);
        send_sample(4, SPOT_ONE);
        send_sample(5, 32'h8000_0000);
        send_sample(6, SPOT_ONE);
        send_sample(3, 32'h0002_0000);   // out of order against the stored log
        drain();

        // maturity on the seed date, zero year fraction, largest strike
        load_terms(0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_sample(0, 32'h0);
        send_sample(1, SPOT_ONE);
        drain();

        // drive the sum into saturation and the flow into its clamp
        load_terms(9, 32'h1, 32'h7FFF_FFFF, 32'h0);
        send_sample(0, 32'h0);
        for (t = 1; t <= 9; t++) send_sample(DATE_W'(t), t[0] ? 32'hFFFF_FFFF : 32'h0);
        send_sample(12'hFFF, $urandom);
        drain();

        // random phases: fresh terms, then a few paths of random content
        while (samples_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       mat = 0;
                1:       mat = 12'hFFF;
                default: mat = DATE_W'($urandom_range(1, 10));
            endcase
            case ($urandom_range(0, 5))
                0:       yf = 0;
                1:       yf = 32'hFFFF_FFFF;
                2:       yf = $urandom;
                default: yf = $urandom_range(32'h0020_0000, 32'h0200_0000);
            endcase
            load_terms(mat, yf, pick_notional(),
                       $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0100_0000));
            for (p = 0; p < 4; p++) begin
                span = (mat > 12) ? 12 : mat + $urandom_range(0, 2);
                send_sample(0, pick_spot());
                for (t = 1; t <= span; t++) begin
                    if ($urandom_range(0, 11) == 0)
                        send_sample(DATE_W'($urandom_range(0, 4095)), pick_spot());
                    else
                        send_sample(DATE_W'(t), pick_spot());
                end
                // once, let the receiver sit idle while samples keep coming
                if (p == 1 && !long_hold && samples_sent > ITEM_TARGET / 2)
                    long_hold = 1;
            end
            drain();
        end

        // final tail already waited out by the last drain
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
